### hw/rtl/playfair_digraph_cipher_assert.svh
// Assertion macros for the Playfair digraph cipher block.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH
`ifndef SYNTHESIS
`define PFC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("playfair cipher check failed");
`define PFC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("playfair cipher check failed");
`else
`define PFC_ASSERT(label, prop)
`define PFC_ASSERT_ALWAYS(label, prop)
`endif
`endif

### hw/rtl/pfc_pkg.sv
// Types, constants and helpers shared by the Playfair cipher modules.
`default_nettype none
package pfc_pkg;

    localparam int CODE_W = 5;
    localparam int SIDE   = 5;
    localparam int ROW_W  = CODE_W * SIDE;
    localparam int IDX_W  = 3;

    typedef logic [CODE_W-1:0] letter_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef row_t [SIDE-1:0]   square_t;
    typedef logic [IDX_W-1:0]  idx_t;

    typedef struct packed {
        logic found;
        idx_t row;
        idx_t col;
    } loc_t;

    localparam letter_t LETTER_I    = 5'd8;
    localparam letter_t LETTER_J    = 5'd9;
    localparam letter_t LETTER_X    = 5'd23;
    localparam letter_t LETTER_LAST = 5'd25;

    localparam idx_t IDX_LAST = 3'd4;

    localparam idx_t REG_ROW0 = 3'd0;
    localparam idx_t REG_ROW1 = 3'd1;
    localparam idx_t REG_ROW2 = 3'd2;
    localparam idx_t REG_ROW3 = 3'd3;
    localparam idx_t REG_ROW4 = 3'd4;

    localparam square_t SQUARE_RESET = {
        25'd27025109, 25'd21613104, 25'd16201099, 25'd10755269, 25'd4294688
    };

    function automatic letter_t cell_of(square_t sq, idx_t r, idx_t c);
        row_t rw;
        rw = sq[r];
        return rw[CODE_W*c +: CODE_W];
    endfunction

    // Step right/down when encrypting, left/up when decrypting, wrapping.
    function automatic idx_t step_idx(idx_t i, logic decrypt);
        idx_t res;
        if (decrypt)
        begin
            res = (i == '0) ? IDX_LAST : i - 3'd1;
        end
        else
        begin
            res = (i == IDX_LAST) ? '0 : i + 3'd1;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/playfair_digraph_cipher.sv
// Top level of the Playfair digraph cipher: key square, input and result stages.
// A beat is registered in the input stage, then in the result stage, which drives the outputs.
// Throughput: one digraph per cycle while out_ready does not hold the result stage; the search and
// selection between the input register and the result register is combinational.
// Reset: the key square returns to the plain alphabet without J, both stages
// empty; configuration writes are taken in every cycle.
`default_nettype none
`include "playfair_digraph_cipher_assert.svh"
module playfair_digraph_cipher (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire                   mode,
    input  wire pfc_pkg::letter_t first_letter,
    input  wire pfc_pkg::letter_t second_letter,
    input  wire                   pad_second,
    output logic                  out_valid,
    input  wire                   out_ready,
    output pfc_pkg::letter_t      first_out,
    output pfc_pkg::letter_t      second_out,
    output logic                  letter_missing,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire pfc_pkg::idx_t    cfg_index,
    input  wire pfc_pkg::row_t    cfg_data
);
    import pfc_pkg::*;

    square_t square_reg, square_next;

    logic    s1_valid_reg, s1_valid_next;
    logic    mode_reg;
    letter_t first_reg, second_reg;

    logic    out_valid_reg, out_valid_next;
    letter_t first_out_reg, second_out_reg;
    logic    missing_reg;

    logic    s2_ready;
    logic    s1_load;
    logic    s2_load;

    loc_t    loc_a, loc_b;
    letter_t res_first, res_second;
    logic    res_missing;

    assign cfg_ready = 1'b1;

    assign s2_ready = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s2_ready;
    assign s1_load  = in_valid && in_ready;
    assign s2_load  = s1_valid_reg && s2_ready;

    always_comb
    begin
        square_next = square_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ROW0: square_next[0] = cfg_data;
                REG_ROW1: square_next[1] = cfg_data;
                REG_ROW2: square_next[2] = cfg_data;
                REG_ROW3: square_next[3] = cfg_data;
                REG_ROW4: square_next[4] = cfg_data;
                default:  square_next = square_reg;
            endcase
        end
    end

    assign s1_valid_next  = s1_load || (s1_valid_reg && !s2_ready);
    assign out_valid_next = s2_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_reg    <= SQUARE_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            square_reg    <= square_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the beat with the pad letter already substituted, and load the result stage on s2_load.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            mode_reg   <= mode;
            first_reg  <= first_letter;
            second_reg <= pad_second ? LETTER_X : second_letter;
        end
        if (s2_load)
        begin
            first_out_reg  <= res_first;
            second_out_reg <= res_second;
            missing_reg    <= res_missing;
        end
    end

    pfc_locate u_locate_a (
        .square (square_reg),
        .letter (first_reg),
        .loc    (loc_a)
    );

    pfc_locate u_locate_b (
        .square (square_reg),
        .letter (second_reg),
        .loc    (loc_b)
    );

    always_comb
    begin
        res_missing = 1'b0;
        if (!loc_a.found || !loc_b.found)
        begin
            res_first   = first_reg;
            res_second  = second_reg;
            res_missing = 1'b1;
        end
        else if (loc_a.row == loc_b.row)
        begin
            res_first  = cell_of(square_reg, loc_a.row, step_idx(loc_a.col, mode_reg));
            res_second = cell_of(square_reg, loc_b.row, step_idx(loc_b.col, mode_reg));
        end
        else if (loc_a.col == loc_b.col)
        begin
            res_first  = cell_of(square_reg, step_idx(loc_a.row, mode_reg), loc_a.col);
            res_second = cell_of(square_reg, step_idx(loc_b.row, mode_reg), loc_b.col);
        end
        else
        begin
            res_first  = cell_of(square_reg, loc_a.row, loc_b.col);
            res_second = cell_of(square_reg, loc_b.row, loc_a.col);
        end
    end

    assign out_valid      = out_valid_reg;
    assign first_out      = first_out_reg;
    assign second_out     = second_out_reg;
    assign letter_missing = missing_reg;

    `PFC_ASSERT(a_stage_advance, s2_load |=> out_valid_reg)
    `PFC_ASSERT(a_missing_passes, (s2_load && !loc_a.found)
        |=> (missing_reg && first_out_reg == $past(first_reg)))
    `PFC_ASSERT(a_found_matches, (s1_valid_reg && loc_a.found)
        |-> (cell_of(square_reg, loc_a.row, loc_a.col) == first_reg || first_reg == LETTER_J))
    `PFC_ASSERT(a_full_stalls, (out_valid_reg && !out_ready && s1_valid_reg) |-> !in_ready)
    `PFC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!s1_valid_reg && !out_valid_reg))

endmodule
`default_nettype wire

### hw/rtl/pfc_locate.sv
// Letter search over the key square: last match in row-major order.
`default_nettype none
module pfc_locate (
    input  wire pfc_pkg::square_t square,
    input  wire pfc_pkg::letter_t letter,
    output pfc_pkg::loc_t         loc
);
    import pfc_pkg::*;

    letter_t mapped;
    logic    in_range;

    assign mapped   = (letter == LETTER_J) ? LETTER_I : letter;
    assign in_range = (letter <= LETTER_LAST);

    always_comb
    begin
        loc = '0;
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                if (in_range && (cell_of(square, IDX_W'(r), IDX_W'(c)) == mapped))
                begin
                    loc.found = 1'b1;
                    loc.row   = IDX_W'(r);
                    loc.col   = IDX_W'(c);
                end
            end
        end
    end

endmodule
`default_nettype wire

### bench/playfair_digraph_cipher_test.sv
// Self-checking testbench for the Playfair digraph cipher: directed table, then random traffic.
`default_nettype none
module playfair_digraph_cipher_test;
    import pfc_pkg::*;

    localparam logic ENCRYPT = 1'b0;
    localparam logic DECRYPT = 1'b1;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int LONG_HOLD = 120;
    localparam int TAIL_CYCLES = 4;

    typedef struct packed {
        letter_t first;
        letter_t second;
        logic    missing;
    } digraph_out_t;

    typedef struct packed {
        logic         decrypt;
        letter_t      first;
        letter_t      second;
        logic         pad;
        logic         typed;
        digraph_out_t result;
    } digraph_case_t;

    typedef enum {
        SQ_SHUFFLED, SQ_ZERO, SQ_RAW, SQ_J_KEY, SQ_ONES, SQ_CROWDED, SQ_PLAIN
    } square_kind_t;

    localparam digraph_case_t OPENING [22] = '{
        '{ENCRYPT, 5'd0,  5'd25, 1'b0, 1'b1, '{5'd4,  5'd21, 1'b0}},
        '{DECRYPT, 5'd0,  5'd25, 1'b0, 1'b1, '{5'd4,  5'd21, 1'b0}},
        '{ENCRYPT, 5'd31, 5'd0,  1'b0, 1'b1, '{5'd31, 5'd0,  1'b1}},
        '{ENCRYPT, 5'd0,  5'd26, 1'b0, 1'b1, '{5'd0,  5'd26, 1'b1}},
        '{DECRYPT, 5'd26, 5'd5,  1'b1, 1'b1, '{5'd26, 5'd23, 1'b1}},
        '{ENCRYPT, 5'd30, 5'd9,  1'b0, 1'b1, '{5'd30, 5'd9,  1'b1}},
        '{DECRYPT, 5'd31, 5'd31, 1'b0, 1'b1, '{5'd31, 5'd31, 1'b1}},
        '{ENCRYPT, 5'd14, 5'd27, 1'b0, 1'b1, '{5'd14, 5'd27, 1'b1}},
        '{ENCRYPT, 5'd0,  5'd1,  1'b0, 1'b0, '0},
        '{DECRYPT, 5'd0,  5'd4,  1'b0, 1'b0, '0},
        '{ENCRYPT, 5'd4,  5'd3,  1'b0, 1'b0, '0},
        '{ENCRYPT, 5'd25, 5'd20, 1'b0, 1'b0, '0},
        '{DECRYPT, 5'd0,  5'd21, 1'b0, 1'b0, '0},
        '{ENCRYPT, 5'd9,  5'd0,  1'b0, 1'b0, '0},
        '{DECRYPT, 5'd0,  5'd9,  1'b0, 1'b0, '0},
        '{ENCRYPT, 5'd2,  5'd2,  1'b0, 1'b0, '0},
        '{DECRYPT, 5'd9,  5'd8,  1'b0, 1'b0, '0},
        '{ENCRYPT, 5'd12, 5'd0,  1'b1, 1'b0, '0},
        '{DECRYPT, 5'd23, 5'd31, 1'b1, 1'b0, '0},
        '{DECRYPT, 5'd21, 5'd16, 1'b0, 1'b0, '0},
        '{ENCRYPT, 5'd7,  5'd18, 1'b0, 1'b0, '0},
        '{ENCRYPT, 5'd31, 5'd31, 1'b1, 1'b0, '0}
    };

    logic    clk = 1'b0;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    logic    mode;
    letter_t first_letter;
    letter_t second_letter;
    logic    pad_second;
    logic    out_valid;
    logic    out_ready;
    letter_t first_out;
    letter_t second_out;
    logic    letter_missing;
    logic    cfg_valid;
    logic    cfg_ready;
    idx_t    cfg_index;
    row_t    cfg_data;

    square_t      key_square;
    digraph_out_t pending_digraphs [$];
    int           error_count = 0;
    int           send_idle_pct = 22;
    int           recv_idle_pct = 78;
    int           holds_asked = 0;

    playfair_digraph_cipher dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .first_letter   (first_letter),
        .second_letter  (second_letter),
        .pad_second     (pad_second),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .first_out      (first_out),
        .second_out     (second_out),
        .letter_missing (letter_missing),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic letter_t square_cell(int r, int c);
        return key_square[r][CODE_W*c +: CODE_W];
    endfunction

    function automatic digraph_out_t encipher_digraph(logic decrypt, letter_t a,
                                                      letter_t b_in, logic pad);
        letter_t      b;
        letter_t      ma;
        letter_t      mb;
        int           r1;
        int           c1;
        int           r2;
        int           c2;
        int           shift;
        logic         fa;
        logic         fb;
        digraph_out_t res;
        b  = pad ? LETTER_X : b_in;
        ma = (a == LETTER_J) ? LETTER_I : a;
        mb = (b == LETTER_J) ? LETTER_I : b;
        fa = 1'b0;
        fb = 1'b0;
        r1 = 0;
        c1 = 0;
        r2 = 0;
        c2 = 0;
        shift = decrypt ? SIDE - 1 : 1;
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                if (ma <= LETTER_LAST && square_cell(r, c) == ma)
                begin
                    r1 = r;
                    c1 = c;
                    fa = 1'b1;
                end
                if (mb <= LETTER_LAST && square_cell(r, c) == mb)
                begin
                    r2 = r;
                    c2 = c;
                    fb = 1'b1;
                end
            end
        end
        if (!(fa && fb))
            res = '{a, b, 1'b1};
        else if (r1 == r2)
            res = '{square_cell(r1, (c1 + shift) % SIDE),
                    square_cell(r2, (c2 + shift) % SIDE), 1'b0};
        else if (c1 == c2)
            res = '{square_cell((r1 + shift) % SIDE, c1),
                    square_cell((r2 + shift) % SIDE, c2), 1'b0};
        else
            res = '{square_cell(r1, c2), square_cell(r2, c1), 1'b0};
        return res;
    endfunction

    function automatic square_t build_square(square_kind_t kind);
        letter_t pool [25];
        letter_t t;
        square_t sq;
        int      n;
        int      k;
        n = 0;
        for (int code = 0; code <= LETTER_LAST; code++)
        begin
            if (letter_t'(code) != LETTER_J)
            begin
                pool[n] = letter_t'(code);
                if (kind == SQ_J_KEY && pool[n] == LETTER_I)
                    pool[n] = LETTER_J;
                n++;
            end
        end
        for (int i = 24; i > 0; i--)
        begin
            k = $urandom_range(i);
            t = pool[i];
            pool[i] = pool[k];
            pool[k] = t;
        end
        for (int i = 0; i < 25; i++)
            sq[i / SIDE][CODE_W*(i % SIDE) +: CODE_W] = pool[i];
        case (kind)
            SQ_ZERO:  sq = '0;
            SQ_ONES:  sq = '1;
            SQ_PLAIN: sq = SQUARE_RESET;
            SQ_RAW:
                for (int r = 0; r < SIDE; r++)
                    sq[r] = row_t'($urandom);
            SQ_CROWDED:
                for (int i = 0; i < 25; i++)
                    sq[i / SIDE][CODE_W*(i % SIDE) +: CODE_W] = letter_t'($urandom_range(3));
            default: ;
        endcase
        return sq;
    endfunction

    // Favour letters that sit in the square so every rule gets exercised.
    function automatic letter_t pick_letter();
        int roll;
        roll = $urandom_range(9);
        if (roll < 6)
            return square_cell($urandom_range(SIDE - 1), $urandom_range(SIDE - 1));
        else if (roll == 6)
            return LETTER_J;
        else
            return letter_t'($urandom_range(31));
    endfunction

    task automatic offer_digraph(input logic decrypt, input letter_t a, input letter_t b,
                                 input logic pad, input logic typed,
                                 input digraph_out_t typed_result);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= decrypt;
        first_letter  <= a;
        second_letter <= b;
        pad_second    <= pad;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (typed)
            pending_digraphs.push_back(typed_result);
        else
            pending_digraphs.push_back(encipher_digraph(decrypt, a, b, pad));
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_digraphs.size() != 0);
    endtask

    task automatic load_square(input square_t sq);
        for (int r = 0; r < SIDE; r++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_t'(r);
            cfg_data  <= sq[r];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            key_square[r] = sq[r];
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Drop out_ready at random, or for a long stretch when one is asked for.
    initial
    begin
        int hold_left;
        int holds_served;
        hold_left = 0;
        holds_served = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_served != holds_asked)
            begin
                hold_left = LONG_HOLD;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        digraph_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_digraphs.size() == 0)
            begin
                $display("%0t unexpected beat: got %0d %0d %0d", $time,
                         first_out, second_out, letter_missing);
                error_count++;
            end
            else
            begin
                want = pending_digraphs.pop_front();
                if (first_out !== want.first)
                begin
                    $display("%0t first_out: expected %0d, got %0d", $time,
                             want.first, first_out);
                    error_count++;
                end
                if (second_out !== want.second)
                begin
                    $display("%0t second_out: expected %0d, got %0d", $time,
                             want.second, second_out);
                    error_count++;
                end
                if (letter_missing !== want.missing)
                begin
                    $display("%0t letter_missing: expected %0d, got %0d", $time,
                             want.missing, letter_missing);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        square_kind_t schedule [PHASES];
        schedule = '{SQ_SHUFFLED, SQ_ZERO, SQ_RAW, SQ_J_KEY,
                     SQ_ONES, SQ_SHUFFLED, SQ_CROWDED, SQ_PLAIN};
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = ENCRYPT;
        first_letter  = '0;
        second_letter = '0;
        pad_second    = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_ROW0;
        cfg_data      = '0;
        key_square    = SQUARE_RESET;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        foreach (OPENING[i])
            offer_digraph(OPENING[i].decrypt, OPENING[i].first, OPENING[i].second,
                          OPENING[i].pad, OPENING[i].typed, OPENING[i].result);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            if (phase < 3)
            begin
                send_idle_pct = 22;
                recv_idle_pct = 78;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_square(build_square(schedule[phase]));
            if (phase == PHASES - 1)
                holds_asked++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                offer_digraph(1'($urandom_range(1)), pick_letter(), pick_letter(),
                              $urandom_range(7) == 0, 1'b0, '0);
        end
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_digraphs.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
